FILE: hdl/pom_pkg.sv
// Shared definitions for the perturb-and-observe MPPT tracker.
// Field widths, register indexes, reset values and the configuration struct.
// No dependencies.
package pom_pkg;

  localparam int DEF_WINDOW_DEPTH = 128;
  localparam int DEF_ADC_BITS     = 12;

  localparam int AVG_W   = 19;
  localparam int POWER_W = 38;
  localparam int REF_W   = 9;
  localparam int STATE_W = 3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 38;

  localparam int OUT_DATA_W = 88;

  localparam logic [CFG_IDX_W-1:0] REG_VOLT_OFFSET    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CURR_OFFSET    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_DEADBAND = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VREF_STEP      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VREF_MIN       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VREF_MAX       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_VREF_RESTART   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_VREF_INITIAL   = 3'd7;

  localparam logic [AVG_W-1:0]   RST_VOLT_OFFSET    = 19'd4684;
  localparam logic [AVG_W-1:0]   RST_CURR_OFFSET    = 19'd105;
  localparam logic [POWER_W-1:0] RST_POWER_DEADBAND = 38'd17790000;
  localparam logic [REF_W-1:0]   RST_VREF_STEP      = 9'd1;
  localparam logic [REF_W-1:0]   RST_VREF_MIN       = 9'd80;
  localparam logic [REF_W-1:0]   RST_VREF_MAX       = 9'd380;
  localparam logic [REF_W-1:0]   RST_VREF_RESTART   = 9'd304;
  localparam logic [REF_W-1:0]   RST_VREF_INITIAL   = 9'd300;

  localparam logic [REF_W-1:0]   DUTY_FULL_SCALE    = 9'd400;

  typedef struct packed {
    logic [AVG_W-1:0]   volt_offset;
    logic [AVG_W-1:0]   curr_offset;
    logic [POWER_W-1:0] power_deadband;
    logic [REF_W-1:0]   vref_step;
    logic [REF_W-1:0]   vref_min;
    logic [REF_W-1:0]   vref_max;
    logic [REF_W-1:0]   vref_restart;
    logic [REF_W-1:0]   vref_initial;
  } cfg_t;

endpackage

FILE: hdl/pom_ring.sv
// Sample ring memory and running window sums.
// Reads the oldest sample on accept, updates the sums and writes the new one back.
// Depends on pom_pkg.
module pom_ring #(
  parameter int WINDOW_DEPTH = pom_pkg::DEF_WINDOW_DEPTH,
  parameter int ADC_BITS     = pom_pkg::DEF_ADC_BITS,
  parameter int SUM_W        = ADC_BITS + $clog2(WINDOW_DEPTH)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ADC_BITS-1:0] volt_sample,
  input  logic [ADC_BITS-1:0] curr_sample,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SUM_W-1:0]    volt_sum,
  output logic [SUM_W-1:0]    curr_sum
);

  localparam int IDX_W = $clog2(WINDOW_DEPTH);
  localparam int MEM_W = 2 * ADC_BITS;

  logic [MEM_W-1:0] ring_mem [WINDOW_DEPTH];
  logic [MEM_W-1:0] rd_data;

  logic [IDX_W-1:0]    write_index;
  logic                wrapped;
  logic                s1_valid;
  logic [IDX_W-1:0]    s1_index;
  logic                s1_old_ok;
  logic [ADC_BITS-1:0] s1_volt;
  logic [ADC_BITS-1:0] s1_curr;

  logic                adv2;
  logic                adv1;
  logic                accept;
  logic [ADC_BITS-1:0] old_volt;
  logic [ADC_BITS-1:0] old_curr;
  logic [SUM_W-1:0]    volt_sum_next;
  logic [SUM_W-1:0]    curr_sum_next;

  assign adv2     = !out_valid || out_ready;
  assign adv1     = !s1_valid || adv2;
  assign in_ready = adv1;
  assign accept   = in_valid && adv1;

  assign old_volt = s1_old_ok ? rd_data[ADC_BITS-1:0] : '0;
  assign old_curr = s1_old_ok ? rd_data[MEM_W-1:ADC_BITS] : '0;

  assign volt_sum_next = volt_sum - SUM_W'(old_volt) + SUM_W'(s1_volt);
  assign curr_sum_next = curr_sum - SUM_W'(old_curr) + SUM_W'(s1_curr);

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= ring_mem[write_index];
    end
    if (adv2 && s1_valid) begin
      ring_mem[s1_index] <= {s1_curr, s1_volt};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      wrapped     <= 1'b0;
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      volt_sum    <= '0;
      curr_sum    <= '0;
    end else begin
      if (adv1) begin
        s1_valid <= in_valid;
      end
      if (accept) begin
        s1_index  <= write_index;
        s1_old_ok <= wrapped;
        s1_volt   <= volt_sample;
        s1_curr   <= curr_sample;
        if (write_index == IDX_W'(WINDOW_DEPTH - 1)) begin
          write_index <= '0;
          wrapped     <= 1'b1;
        end else begin
          write_index <= write_index + 1'b1;
        end
      end
      if (adv2) begin
        out_valid <= s1_valid;
        if (s1_valid) begin
          volt_sum <= volt_sum_next;
          curr_sum <= curr_sum_next;
        end
      end
    end
  end

endmodule

FILE: hdl/pom_power.sv
// Offset correction with clamp at zero, then the power product.
// Two registered stages between the window sums and the tracking machine.
// Depends on pom_pkg.
module pom_power #(
  parameter int SUM_W   = pom_pkg::DEF_ADC_BITS + $clog2(pom_pkg::DEF_WINDOW_DEPTH),
  parameter int POWER_W = 2 * SUM_W
) (
  input  logic                         clk,
  input  logic                         rst,
  input  pom_pkg::cfg_t                cfg,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [SUM_W-1:0]             volt_sum,
  input  logic [SUM_W-1:0]             curr_sum,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [SUM_W-1:0]             volt_corr,
  output logic [SUM_W-1:0]             curr_corr,
  output logic [POWER_W-1:0]           power
);

  localparam int OFS_W = (SUM_W > pom_pkg::AVG_W) ? SUM_W : pom_pkg::AVG_W;

  logic               s3_valid;
  logic [SUM_W-1:0]   s3_volt;
  logic [SUM_W-1:0]   s3_curr;
  logic               adv4;
  logic               adv3;
  logic [OFS_W-1:0]   volt_ext;
  logic [OFS_W-1:0]   curr_ext;
  logic [OFS_W-1:0]   volt_ofs;
  logic [OFS_W-1:0]   curr_ofs;
  logic [SUM_W-1:0]   volt_clamp;
  logic [SUM_W-1:0]   curr_clamp;

  assign adv4     = !out_valid || out_ready;
  assign adv3     = !s3_valid || adv4;
  assign in_ready = adv3;

  assign volt_ext = OFS_W'(volt_sum);
  assign curr_ext = OFS_W'(curr_sum);
  assign volt_ofs = OFS_W'(cfg.volt_offset);
  assign curr_ofs = OFS_W'(cfg.curr_offset);

  assign volt_clamp = (volt_ext > volt_ofs) ? SUM_W'(volt_ext - volt_ofs) : '0;
  assign curr_clamp = (curr_ext > curr_ofs) ? SUM_W'(curr_ext - curr_ofs) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv3) begin
        s3_valid <= in_valid;
        if (in_valid) begin
          s3_volt <= volt_clamp;
          s3_curr <= curr_clamp;
        end
      end
      if (adv4) begin
        out_valid <= s3_valid;
        if (s3_valid) begin
          volt_corr <= s3_volt;
          curr_corr <= s3_curr;
          power     <= POWER_W'(s3_volt) * POWER_W'(s3_curr);
        end
      end
    end
  end

endmodule

FILE: hdl/pom_track.sv
// Perturb-and-observe machine: power and voltage compares, reference update
// and the registered result. Depends on pom_pkg.
module pom_track #(
  parameter int SUM_W   = pom_pkg::DEF_ADC_BITS + $clog2(pom_pkg::DEF_WINDOW_DEPTH),
  parameter int POWER_W = 2 * SUM_W
) (
  input  logic                             clk,
  input  logic                             rst,
  input  pom_pkg::cfg_t                    cfg,
  input  logic                             vref_load,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [SUM_W-1:0]                 volt_corr,
  input  logic [SUM_W-1:0]                 curr_corr,
  input  logic [POWER_W-1:0]               power,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [pom_pkg::REF_W-1:0]        duty_quarter_pct,
  output logic [pom_pkg::POWER_W-1:0]      power_value,
  output logic [pom_pkg::AVG_W-1:0]        volt_avg_sum,
  output logic [pom_pkg::AVG_W-1:0]        curr_avg_sum,
  output logic [pom_pkg::STATE_W-1:0]      track_state
);

  localparam int CMP_W = (POWER_W > pom_pkg::POWER_W) ? POWER_W : pom_pkg::POWER_W;
  localparam int REF_W = pom_pkg::REF_W;

  typedef enum logic [pom_pkg::STATE_W-1:0] {
    ST_CHECK  = 3'd0,
    ST_CHANGE = 3'd1,
    ST_PUP    = 3'd2,
    ST_PDOWN  = 3'd3,
    ST_VUP    = 3'd4,
    ST_VDOWN  = 3'd5
  } mode_t;

  mode_t              mode;
  mode_t              mode_next;
  logic [REF_W-1:0]   vref;
  logic [REF_W-1:0]   vref_next;
  logic [POWER_W-1:0] prev_power;
  logic [SUM_W-1:0]   prev_volt;

  logic               s5_valid;
  logic               s5_zero;
  logic               s5_power_up;
  logic               s5_volt_up;
  logic               s5_small;
  logic [POWER_W-1:0] s5_power;
  logic [SUM_W-1:0]   s5_volt;
  logic [SUM_W-1:0]   s5_curr;

  logic               adv6;
  logic               adv5;
  logic [POWER_W-1:0] power_diff;
  logic [REF_W:0]     vref_up;
  logic [REF_W-1:0]   duty_next;

  assign adv6     = !out_valid || out_ready;
  assign adv5     = !s5_valid || adv6;
  assign in_ready = adv5;

  assign power_diff = (power > prev_power) ? power - prev_power : prev_power - power;
  assign vref_up    = {1'b0, vref} + {1'b0, cfg.vref_step};

  always_comb begin
    mode_next = ST_CHECK;
    vref_next = vref;
    case (mode)
      ST_CHANGE: begin
        mode_next = s5_power_up ? ST_PUP : ST_PDOWN;
      end
      ST_PUP: begin
        mode_next = s5_volt_up ? ST_VUP : ST_VDOWN;
      end
      ST_PDOWN: begin
        mode_next = s5_volt_up ? ST_VDOWN : ST_VUP;
      end
      ST_VUP: begin
        vref_next = (vref_up > {1'b0, cfg.vref_max}) ? cfg.vref_max : vref_up[REF_W-1:0];
      end
      ST_VDOWN: begin
        if (cfg.vref_step > vref || (vref - cfg.vref_step) < cfg.vref_min) begin
          vref_next = cfg.vref_min;
        end else begin
          vref_next = vref - cfg.vref_step;
        end
      end
      ST_CHECK: begin
        if (s5_zero) begin
          vref_next = cfg.vref_restart;
        end else if (!s5_small) begin
          mode_next = ST_CHANGE;
        end
      end
      default: begin
        mode_next = ST_CHECK;
      end
    endcase
    duty_next = (vref_next >= pom_pkg::DUTY_FULL_SCALE) ?
                '0 : pom_pkg::DUTY_FULL_SCALE - vref_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= ST_CHECK;
      vref       <= pom_pkg::RST_VREF_INITIAL;
      prev_power <= '0;
      prev_volt  <= '0;
      s5_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (adv5) begin
        s5_valid <= in_valid;
        if (in_valid) begin
          s5_zero     <= (power == '0);
          s5_power_up <= (power > prev_power);
          s5_volt_up  <= (volt_corr > prev_volt);
          s5_small    <= (CMP_W'(power_diff) < CMP_W'(cfg.power_deadband));
          s5_power    <= power;
          s5_volt     <= volt_corr;
          s5_curr     <= curr_corr;
          prev_power  <= power;
          prev_volt   <= volt_corr;
        end
      end
      if (adv6) begin
        out_valid <= s5_valid;
        if (s5_valid) begin
          mode             <= mode_next;
          vref             <= vref_next;
          duty_quarter_pct <= duty_next;
          power_value      <= pom_pkg::POWER_W'(s5_power);
          volt_avg_sum     <= pom_pkg::AVG_W'(s5_volt);
          curr_avg_sum     <= pom_pkg::AVG_W'(s5_curr);
          track_state      <= mode_next;
        end
      end
      if (vref_load) begin
        vref <= cfg.vref_initial;
      end
    end
  end

endmodule

FILE: hdl/perturb_observe_mppt_tracker.sv
// Perturb-and-observe MPPT tracker: ring memory, sums, power and tracking machine.
// Registered path: ring read and sums, offset clamp and power product, compares and tracker result.
// Throughput: one item per cycle while m_tready does not hold the output.
// Reset (rst, synchronous): control, sums, tracking state and configuration return to defaults;
// the ring memory is not swept, entries read as zero until the first wrap of the write index.
// Depends on pom_pkg, pom_ring, pom_power, pom_track.
module perturb_observe_mppt_tracker #(
  parameter int WINDOW_DEPTH = pom_pkg::DEF_WINDOW_DEPTH,
  parameter int ADC_BITS     = pom_pkg::DEF_ADC_BITS
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  // volt_sample, curr_sample
  input  logic [((2 * ADC_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  // duty_quarter_pct, power_value, volt_avg_sum, curr_avg_sum, track_state
  output logic [pom_pkg::OUT_DATA_W-1:0]          m_tdata,
  input  logic                                    cfg_we,
  input  logic [pom_pkg::CFG_IDX_W-1:0]           cfg_addr,
  input  logic [pom_pkg::CFG_DATA_W-1:0]          cfg_data
);

  localparam int SUM_W   = ADC_BITS + $clog2(WINDOW_DEPTH);
  localparam int POWER_W = 2 * SUM_W;

  pom_pkg::cfg_t cfg;
  logic          vref_load;

  logic               sum_valid;
  logic               sum_ready;
  logic [SUM_W-1:0]   volt_sum;
  logic [SUM_W-1:0]   curr_sum;
  logic               pwr_valid;
  logic               pwr_ready;
  logic [SUM_W-1:0]   volt_corr;
  logic [SUM_W-1:0]   curr_corr;
  logic [POWER_W-1:0] power;

  logic [pom_pkg::REF_W-1:0]   duty_quarter_pct;
  logic [pom_pkg::POWER_W-1:0] power_value;
  logic [pom_pkg::AVG_W-1:0]   volt_avg_sum;
  logic [pom_pkg::AVG_W-1:0]   curr_avg_sum;
  logic [pom_pkg::STATE_W-1:0] track_state;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.volt_offset    <= pom_pkg::RST_VOLT_OFFSET;
      cfg.curr_offset    <= pom_pkg::RST_CURR_OFFSET;
      cfg.power_deadband <= pom_pkg::RST_POWER_DEADBAND;
      cfg.vref_step      <= pom_pkg::RST_VREF_STEP;
      cfg.vref_min       <= pom_pkg::RST_VREF_MIN;
      cfg.vref_max       <= pom_pkg::RST_VREF_MAX;
      cfg.vref_restart   <= pom_pkg::RST_VREF_RESTART;
      cfg.vref_initial   <= pom_pkg::RST_VREF_INITIAL;
      vref_load          <= 1'b0;
    end else begin
      vref_load <= cfg_we && (cfg_addr == pom_pkg::REG_VREF_INITIAL);
      if (cfg_we) begin
        case (cfg_addr)
          pom_pkg::REG_VOLT_OFFSET:    cfg.volt_offset    <= cfg_data[pom_pkg::AVG_W-1:0];
          pom_pkg::REG_CURR_OFFSET:    cfg.curr_offset    <= cfg_data[pom_pkg::AVG_W-1:0];
          pom_pkg::REG_POWER_DEADBAND: cfg.power_deadband <= cfg_data[pom_pkg::POWER_W-1:0];
          pom_pkg::REG_VREF_STEP:      cfg.vref_step      <= cfg_data[pom_pkg::REF_W-1:0];
          pom_pkg::REG_VREF_MIN:       cfg.vref_min       <= cfg_data[pom_pkg::REF_W-1:0];
          pom_pkg::REG_VREF_MAX:       cfg.vref_max       <= cfg_data[pom_pkg::REF_W-1:0];
          pom_pkg::REG_VREF_RESTART:   cfg.vref_restart   <= cfg_data[pom_pkg::REF_W-1:0];
          pom_pkg::REG_VREF_INITIAL:   cfg.vref_initial   <= cfg_data[pom_pkg::REF_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  pom_ring #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .ADC_BITS     (ADC_BITS),
    .SUM_W        (SUM_W)
  ) u_ring (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .volt_sample (s_tdata[ADC_BITS-1:0]),
    .curr_sample (s_tdata[2*ADC_BITS-1:ADC_BITS]),
    .out_valid   (sum_valid),
    .out_ready   (sum_ready),
    .volt_sum    (volt_sum),
    .curr_sum    (curr_sum)
  );

  pom_power #(
    .SUM_W   (SUM_W),
    .POWER_W (POWER_W)
  ) u_power (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (sum_valid),
    .in_ready  (sum_ready),
    .volt_sum  (volt_sum),
    .curr_sum  (curr_sum),
    .out_valid (pwr_valid),
    .out_ready (pwr_ready),
    .volt_corr (volt_corr),
    .curr_corr (curr_corr),
    .power     (power)
  );

  pom_track #(
    .SUM_W   (SUM_W),
    .POWER_W (POWER_W)
  ) u_track (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .vref_load        (vref_load),
    .in_valid         (pwr_valid),
    .in_ready         (pwr_ready),
    .volt_corr        (volt_corr),
    .curr_corr        (curr_corr),
    .power            (power),
    .out_valid        (m_tvalid),
    .out_ready        (m_tready),
    .duty_quarter_pct (duty_quarter_pct),
    .power_value      (power_value),
    .volt_avg_sum     (volt_avg_sum),
    .curr_avg_sum     (curr_avg_sum),
    .track_state      (track_state)
  );

  assign m_tdata = {track_state, curr_avg_sum, volt_avg_sum, power_value, duty_quarter_pct};

endmodule

FILE: hdl/pom_checker.sv
// Port-level checks for the MPPT tracker, bound to the top level.
// Depends on pom_pkg and perturb_observe_mppt_tracker.
module pom_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [pom_pkg::OUT_DATA_W-1:0] m_tdata
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[pom_pkg::REF_W-1:0] <= pom_pkg::DUTY_FULL_SCALE)
    else $error("duty above full scale");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid && !$past(rst) |-> s_tready)
    else $error("input stalled with empty output");

endmodule

bind perturb_observe_mppt_tracker pom_checker u_pom_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: tb/perturb_observe_mppt_tracker_tb.sv
// Testbench for perturb_observe_mppt_tracker: streams voltage/current sample pairs,
// predicts each tracker result in a scoreboard class and compares field by field.
// Depends on pom_pkg and the tracker RTL.
`timescale 1ns / 1ps

module perturb_observe_mppt_tracker_tb;
  import pom_pkg::*;

  localparam int SAMPLE_W  = DEF_ADC_BITS;
  localparam int IN_DATA_W = ((2 * DEF_ADC_BITS + 7) / 8) * 8;

  typedef enum logic [STATE_W-1:0] {
    TRK_CHECK  = 3'd0,
    TRK_CHANGE = 3'd1,
    TRK_P_UP   = 3'd2,
    TRK_P_DOWN = 3'd3,
    TRK_V_UP   = 3'd4,
    TRK_V_DOWN = 3'd5
  } track_mode_e;

  typedef struct {
    logic [REF_W-1:0]   duty;
    logic [POWER_W-1:0] power;
    logic [AVG_W-1:0]   volt_avg;
    logic [AVG_W-1:0]   curr_avg;
    logic [STATE_W-1:0] state;
  } tracker_result_t;

  class mppt_scoreboard;
    cfg_t               regs;
    logic [SAMPLE_W-1:0] volt_hist [DEF_WINDOW_DEPTH];
    logic [SAMPLE_W-1:0] curr_hist [DEF_WINDOW_DEPTH];
    int                 hist_pos;
    logic [AVG_W-1:0]   volt_total;
    logic [AVG_W-1:0]   curr_total;
    logic [POWER_W-1:0] last_power;
    logic [AVG_W-1:0]   last_volt;
    track_mode_e        mode;
    logic [REF_W-1:0]   vref;
    tracker_result_t    expected_q[$];
    int                 errors;

    function new();
      regs.volt_offset    = RST_VOLT_OFFSET;
      regs.curr_offset    = RST_CURR_OFFSET;
      regs.power_deadband = RST_POWER_DEADBAND;
      regs.vref_step      = RST_VREF_STEP;
      regs.vref_min       = RST_VREF_MIN;
      regs.vref_max       = RST_VREF_MAX;
      regs.vref_restart   = RST_VREF_RESTART;
      regs.vref_initial   = RST_VREF_INITIAL;
      for (int i = 0; i < DEF_WINDOW_DEPTH; i++) begin
        volt_hist[i] = '0;
        curr_hist[i] = '0;
      end
      hist_pos   = 0;
      volt_total = '0;
      curr_total = '0;
      last_power = '0;
      last_volt  = '0;
      mode       = TRK_CHECK;
      vref       = RST_VREF_INITIAL;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_VOLT_OFFSET:    regs.volt_offset    = val[AVG_W-1:0];
        REG_CURR_OFFSET:    regs.curr_offset    = val[AVG_W-1:0];
        REG_POWER_DEADBAND: regs.power_deadband = val[POWER_W-1:0];
        REG_VREF_STEP:      regs.vref_step      = val[REF_W-1:0];
        REG_VREF_MIN:       regs.vref_min       = val[REF_W-1:0];
        REG_VREF_MAX:       regs.vref_max       = val[REF_W-1:0];
        REG_VREF_RESTART:   regs.vref_restart   = val[REF_W-1:0];
        REG_VREF_INITIAL: begin
          regs.vref_initial = val[REF_W-1:0];
          vref = val[REF_W-1:0];
        end
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_item(logic [IN_DATA_W-1:0] d);
      logic [SAMPLE_W-1:0] vs, cs;
      logic [AVG_W-1:0]    v, c;
      logic [POWER_W-1:0]  p, diff;
      logic [REF_W:0]      raised;
      track_mode_e         nxt;
      tracker_result_t     r;
      vs = d[SAMPLE_W-1:0];
      cs = d[2*SAMPLE_W-1:SAMPLE_W];
      volt_total = volt_total - AVG_W'(volt_hist[hist_pos]) + AVG_W'(vs);
      curr_total = curr_total - AVG_W'(curr_hist[hist_pos]) + AVG_W'(cs);
      volt_hist[hist_pos] = vs;
      curr_hist[hist_pos] = cs;
      hist_pos = (hist_pos + 1) % DEF_WINDOW_DEPTH;
      v = volt_total > regs.volt_offset ? volt_total - regs.volt_offset : '0;
      c = curr_total > regs.curr_offset ? curr_total - regs.curr_offset : '0;
      p = POWER_W'(v) * POWER_W'(c);
      case (mode)
        TRK_CHANGE: nxt = p > last_power ? TRK_P_UP : TRK_P_DOWN;
        TRK_P_UP:   nxt = v > last_volt ? TRK_V_UP : TRK_V_DOWN;
        TRK_P_DOWN: nxt = v > last_volt ? TRK_V_DOWN : TRK_V_UP;
        TRK_V_UP: begin
          raised = {1'b0, vref} + {1'b0, regs.vref_step};
          vref = raised > {1'b0, regs.vref_max} ? regs.vref_max : raised[REF_W-1:0];
          nxt = TRK_CHECK;
        end
        TRK_V_DOWN: begin
          if (regs.vref_step > vref || vref - regs.vref_step < regs.vref_min)
            vref = regs.vref_min;
          else
            vref = vref - regs.vref_step;
          nxt = TRK_CHECK;
        end
        TRK_CHECK: begin
          diff = p > last_power ? p - last_power : last_power - p;
          if (p == '0) begin
            vref = regs.vref_restart;
            nxt = TRK_CHECK;
          end else if (diff < regs.power_deadband) begin
            nxt = TRK_CHECK;
          end else begin
            nxt = TRK_CHANGE;
          end
        end
        default: nxt = TRK_CHECK;
      endcase
      mode       = nxt;
      last_power = p;
      last_volt  = v;
      r.duty     = vref >= DUTY_FULL_SCALE ? '0 : DUTY_FULL_SCALE - vref;
      r.power    = p;
      r.volt_avg = v;
      r.curr_avg = c;
      r.state    = nxt;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] d);
      tracker_result_t got, want;
      got.duty     = d[8:0];
      got.power    = d[46:9];
      got.volt_avg = d[65:47];
      got.curr_avg = d[84:66];
      got.state    = d[87:85];
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected result duty=%0d power=%0d v=%0d c=%0d st=%0d", $realtime,
                   got.duty, got.power, got.volt_avg, got.curr_avg, got.state);
        return;
      end
      want = expected_q.pop_front();
      if (got.duty !== want.duty || got.power !== want.power ||
          got.volt_avg !== want.volt_avg || got.curr_avg !== want.curr_avg ||
          got.state !== want.state) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch exp duty=%0d power=%0d v=%0d c=%0d st=%0d, got duty=%0d power=%0d v=%0d c=%0d st=%0d",
                   $realtime, want.duty, want.power, want.volt_avg, want.curr_avg, want.state,
                   got.duty, got.power, got.volt_avg, got.curr_avg, got.state);
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_data;

  mppt_scoreboard sb;
  int  send_idle_pct;
  int  sink_idle_pct;
  bit  stall_request;
  int  stall_left;

  perturb_observe_mppt_tracker dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(negedge clk) begin
    if (stall_request && stall_left == 0) begin
      stall_left = 400;
      stall_request = 1'b0;
    end
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_item(s_tdata);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
    end
  end

  task automatic send_item(input logic [SAMPLE_W-1:0] volt, input logic [SAMPLE_W-1:0] curr);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {curr, volt};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_all(input logic [AVG_W-1:0] vo, input logic [AVG_W-1:0] co,
                             input logic [POWER_W-1:0] db, input logic [REF_W-1:0] stp,
                             input logic [REF_W-1:0] lo, input logic [REF_W-1:0] hi,
                             input logic [REF_W-1:0] rs, input logic [REF_W-1:0] init);
    drain();
    cfg_write(REG_VOLT_OFFSET, CFG_DATA_W'(vo));
    cfg_write(REG_CURR_OFFSET, CFG_DATA_W'(co));
    cfg_write(REG_POWER_DEADBAND, CFG_DATA_W'(db));
    cfg_write(REG_VREF_STEP, CFG_DATA_W'(stp));
    cfg_write(REG_VREF_MIN, CFG_DATA_W'(lo));
    cfg_write(REG_VREF_MAX, CFG_DATA_W'(hi));
    cfg_write(REG_VREF_RESTART, CFG_DATA_W'(rs));
    cfg_write(REG_VREF_INITIAL, CFG_DATA_W'(init));
  endtask

  function automatic logic [SAMPLE_W-1:0] clamp_sample(int x);
    if (x < 0) return '0;
    if (x > 4095) return 12'hFFF;
    return SAMPLE_W'(x);
  endfunction

  // Mostly slow drifts of both samples so the tracker walks the whole climb;
  // the rest is noise, zero bursts and bursts of each sample at zero or full scale.
  task automatic sample_stream(input int count);
    int sent, kind, len, bv, bc, sv, sc;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(9);
      len  = (kind < 6) ? $urandom_range(10, 40) : $urandom_range(2, 15);
      bv = $urandom_range(4095);
      bc = $urandom_range(4095);
      sv = $urandom_range(60) - 30;
      sc = $urandom_range(60) - 30;
      for (int k = 0; k < len && sent < count; k++) begin
        case (kind)
          0, 1, 2, 3, 4, 5:
            send_item(clamp_sample(bv + sv * k + $urandom_range(16) - 8),
                      clamp_sample(bc + sc * k + $urandom_range(16) - 8));
          6, 7: send_item(SAMPLE_W'($urandom), SAMPLE_W'($urandom));
          8:    send_item('0, '0);
          default: send_item($urandom_range(1) ? 12'hFFF : 12'h000,
                             $urandom_range(1) ? 12'hFFF : 12'h000);
        endcase
        sent++;
      end
    end
  endtask

  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    sb = new();
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    m_tready = 1'b0;
    cfg_we   = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    stall_request = 1'b0;
    stall_left    = 0;
    send_idle_pct = 25;
    sink_idle_pct = 54;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_item(12'h000, 12'h000);
    send_item(12'hFFF, 12'hFFF);
    send_item(12'hFFF, 12'h000);
    send_item(12'h000, 12'hFFF);
    send_item(12'hAAA, 12'h555);
    send_item(12'h555, 12'hAAA);
    for (int i = 0; i < 10; i++) send_item(12'hFFF, 12'hFFF);
    for (int i = 0; i < 4; i++) send_item(12'h001, 12'h001);
    sample_stream(130);

    // references beyond full scale, step larger than the reference, no deadband
    program_all('0, '0, '0, 9'd400, 9'd0, 9'h1FF, 9'h1FF, 9'd450);
    sample_stream(170);

    send_idle_pct = 54;
    sink_idle_pct = 25;
    program_all(19'd524160, 19'd524160, {POWER_W{1'b1}}, 9'd1, 9'd400, 9'd400, 9'd0, 9'd0);
    sample_stream(120);

    program_all(AVG_W'($urandom_range(60000)), AVG_W'($urandom_range(30000)),
                POWER_W'($urandom), REF_W'($urandom_range(1, 20)),
                REF_W'($urandom_range(50, 150)), REF_W'($urandom_range(250, 400)),
                REF_W'($urandom_range(400)), REF_W'($urandom_range(400)));
    stall_request = 1'b1;
    sample_stream(200);

    send_idle_pct = 0;
    sink_idle_pct = 0;
    program_all(AVG_W'($urandom_range(20000)), '0, '0, 9'h1FF, 9'd400, 9'd0, 9'd200, 9'h1FF);
    sample_stream(170);

    program_all(RST_VOLT_OFFSET, RST_CURR_OFFSET, RST_POWER_DEADBAND, RST_VREF_STEP,
                RST_VREF_MIN, RST_VREF_MAX, RST_VREF_RESTART, RST_VREF_INITIAL);
    stall_request = 1'b1;
    sample_stream(200);

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
